// ===== rtl/ftmb_pkg.sv =====
// shared types, constants and tap tables of the five-tap mirrored blur
`default_nettype none

package ftmb_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TAPS       = 5;
   localparam int TAP_IDX_W  = 3;
   localparam int LANES      = 4;
   localparam int LANE_W     = 2;
   localparam int ROW_W      = 12;
   localparam int SIZE_W     = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int MIN_SIZE   = 8;
   localparam int MAX_HEIGHT = 4096;
   localparam int ACC_W      = 24;
   localparam int ROUND_BITS = 8;
   localparam int ROUND_ADD  = 128;
   localparam int RST_SIZE   = 256;

   typedef logic [SAMPLE_W-1:0]              sample_type;
   typedef logic [LANES-1:0][SAMPLE_W-1:0]   line_word_type;
   typedef logic [TAP_IDX_W-1:0]             tap_idx_type;

   // register indexes of the csr channel
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_MODE   = 2'd2
   } csr_reg_type;

   // which mirrored window a result draws its taps from
   typedef enum logic [2:0] {
      PAT_NORMAL = 3'd0,
      PAT_START0 = 3'd1,
      PAT_START1 = 3'd2,
      PAT_END1   = 3'd3,
      PAT_END0   = 3'd4
   } pat_type;

   localparam logic [7:0] WEIGHTS [TAPS] = '{8'd13, 8'd64, 8'd102, 8'd64, 8'd13};

   // window offset (0 is newest) feeding each tap
   localparam tap_idx_type SRC_NORMAL [TAPS] = '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
   localparam tap_idx_type SRC_START0 [TAPS] = '{3'd0, 3'd1, 3'd2, 3'd1, 3'd0};
   localparam tap_idx_type SRC_START1 [TAPS] = '{3'd2, 3'd3, 3'd2, 3'd1, 3'd0};
   localparam tap_idx_type SRC_END1   [TAPS] = '{3'd3, 3'd2, 3'd1, 3'd0, 3'd0};
   localparam tap_idx_type SRC_END0   [TAPS] = '{3'd2, 3'd1, 3'd0, 3'd0, 3'd1};

   function automatic tap_idx_type tap_src(pat_type pat, tap_idx_type k);
      tap_idx_type src;
      unique case (pat)
         PAT_START0: src = SRC_START0[k];
         PAT_START1: src = SRC_START1[k];
         PAT_END1:   src = SRC_END1[k];
         PAT_END0:   src = SRC_END0[k];
         default:    src = SRC_NORMAL[k];
      endcase
      return src;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ftmb_intf.sv =====
// handshake channel interfaces of the five-tap mirrored blur
`default_nettype none

interface ftmb_req_if;
   logic                   valid;
   logic                   ready;
   logic [ftmb_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface ftmb_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [ftmb_pkg::SAMPLE_W-1:0] filtered;
   logic                   last_of_run;
   logic                   end_of_frame;

   modport source (output valid, output filtered, output last_of_run,
                   output end_of_frame, input ready);
   modport sink   (input valid, input filtered, input last_of_run,
                   input end_of_frame, output ready);
endinterface

interface ftmb_csr_if;
   logic                    valid;
   logic                    ready;
   logic [ftmb_pkg::CSR_IDX_W-1:0] index;
   logic [ftmb_pkg::SIZE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/five_tap_mirrored_blur.sv =====
// top level of the five-tap mirrored blur: line memory, tap sequencer, mac and output
//
//   channel   dir   payload                                  handshake
//   req_chan  in    sample                                   valid / ready
//   rsp_chan  out   filtered, last_of_run, end_of_frame     valid / ready
//   csr_chan  in    index, data (0 width, 1 height, 2 mode)  valid / ready, ready always high
//
// one word accepted per cycle while the sequencer is free; a word that flushes (last of a row,
// or of a column in the last row) emits three results from the tap sequencer, one at a time,
// and req_chan.ready stays low until the sequencer hands off the last of them
// a result passes from the accept edge (memory read and sequencer load) through the tap
// register and then the mac register to rsp_chan; a stalled rsp_chan backs up into
// req_chan.ready
// reset is synchronous and clears control and csr state; the line memory has no
// reset and no clearing pass, entries are written before they are read
`default_nettype none

module five_tap_mirrored_blur #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   ftmb_req_if.sink    req_chan,
   ftmb_rsp_if.source  rsp_chan,
   ftmb_csr_if.sink    csr_chan
);
   import ftmb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   // csr registers
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic              vert_ff, vert_in;

   // clamped frame extents, as last index
   logic [31:0]       width_ext, height_ext;
   logic [CW-1:0]     wlast;
   logic [ROW_W-1:0]  hlast;

   // raster position of the next word
   logic [CW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // handshake
   logic              req_acc, csr_acc, csr_hit;
   logic              o_free, c_free;

   // line memory: one word per column, one lane per row modulo four
   line_word_type     line_mem [MAX_WIDTH];
   line_word_type     line_rd_ff;

   // newest five words of the stream, entry 0 is the current one
   sample_type        taps_ff [TAPS];

   // tap sequencer stage
   logic              b_valid_ff, b_valid_in;
   logic              b_vert_ff, b_vert_in;
   logic              b_flush_ff, b_flush_in;
   logic [1:0]        b_step_ff, b_step_in;
   pat_type           b_pat_ff, b_pat_in;
   logic              b_eof_ff, b_eof_in;
   logic [LANE_W-1:0] b_lane_ff, b_lane_in;
   logic              b_emit, b_lastsub, b_fin;
   pat_type           b_pat_cur;
   sample_type        win [TAPS];

   // accept-time decode
   logic              a_emits, a_flush, a_is2, a_is3, a_other_last;

   // tap register stage
   logic              c_valid_ff, c_valid_in;
   sample_type        c_tap_ff [TAPS];
   logic              c_last_ff, c_eof_ff;

   // mac and output register
   logic [ACC_W-1:0]  acc;
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        rsp_data_ff;
   logic              rsp_last_ff, rsp_eof_ff;

   // ---------------------------------------------------------------- handshake
   assign o_free   = !rsp_valid_ff || rsp_chan.ready;
   assign c_free   = !c_valid_ff || o_free;
   assign b_emit   = b_valid_ff && c_free;
   assign b_lastsub = !b_flush_ff || (b_step_ff == 2'd2);
   assign b_fin    = b_emit && b_lastsub;

   // a new word may enter while the sequencer hands off its final result
   assign req_chan.ready = !b_valid_ff || b_fin;
   assign req_acc        = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;
   assign csr_acc        = csr_chan.valid;
   assign csr_hit        = csr_acc && ((csr_chan.index == REG_WIDTH) ||
                                       (csr_chan.index == REG_HEIGHT) ||
                                       (csr_chan.index == REG_MODE));

   // ---------------------------------------------------------------- csr
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      vert_in   = vert_ff;
      if (csr_acc) begin
         unique case (csr_chan.index)
            REG_WIDTH:  width_in  = csr_chan.data;
            REG_HEIGHT: height_in = csr_chan.data;
            REG_MODE:   vert_in   = csr_chan.data[0];
            default: ;  // unknown index, ignored
         endcase
      end
   end

   // sizes outside the legal range clamp to it
   assign width_ext  = 32'(width_ff);
   assign height_ext = 32'(height_ff);
   assign wlast = (width_ext < 32'(MIN_SIZE))  ? CW'(MIN_SIZE - 1) :
                  (width_ext > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
                                                 CW'(width_ext - 32'd1);
   assign hlast = (height_ext < 32'(MIN_SIZE))   ? ROW_W'(MIN_SIZE - 1) :
                  (height_ext > 32'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT - 1) :
                                                   ROW_W'(height_ext - 32'd1);

   // ---------------------------------------------------------------- position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (csr_hit) begin
         // any register write restarts the frame
         col_in = '0;
         row_in = '0;
      end else if (req_acc) begin
         if (col_ff == wlast) begin
            col_in = '0;
            row_in = (row_ff == hlast) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else begin
         col_in = col_ff;
      end
   end

   // ---------------------------------------------------------------- line memory
   // read-before-write: the lane being replaced is the row four back, still needed
   always_ff @(posedge clock) begin
      if (req_acc) begin
         line_mem[col_ff][row_ff[LANE_W-1:0]] <= req_chan.sample;
         line_rd_ff                           <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         taps_ff[0] <= req_chan.sample;
         for (int j = 1; j < TAPS; j++) begin
            taps_ff[j] <= taps_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------- accept decode
   always_comb begin
      if (vert_ff) begin
         a_emits      = row_ff >= ROW_W'(2);
         a_flush      = row_ff == hlast;
         a_is2        = row_ff == ROW_W'(2);
         a_is3        = row_ff == ROW_W'(3);
         a_other_last = col_ff == wlast;
      end else begin
         a_emits      = col_ff >= CW'(2);
         a_flush      = col_ff == wlast;
         a_is2        = col_ff == CW'(2);
         a_is3        = col_ff == CW'(3);
         a_other_last = row_ff == hlast;
      end
   end

   // ---------------------------------------------------------------- tap sequencer
   always_comb begin
      b_valid_in = b_valid_ff;
      b_vert_in  = b_vert_ff;
      b_flush_in = b_flush_ff;
      b_step_in  = b_step_ff;
      b_pat_in   = b_pat_ff;
      b_eof_in   = b_eof_ff;
      b_lane_in  = b_lane_ff;
      priority if (req_acc) begin
         // a word near the start of a row or column emits nothing
         b_valid_in = a_emits;
         b_vert_in  = vert_ff;
         b_flush_in = a_flush;
         b_step_in  = 2'd0;
         b_pat_in   = a_is2 ? PAT_START0 : (a_is3 ? PAT_START1 : PAT_NORMAL);
         b_eof_in   = a_other_last;
         b_lane_in  = row_ff[LANE_W-1:0];
      end else if (b_fin) begin
         b_valid_in = 1'b0;
      end else if (b_emit) begin
         b_step_in = b_step_ff + 2'd1;
      end else begin
         b_valid_in = b_valid_ff;
      end
   end

   // flush walks centers n-3, n-2, n-1
   always_comb begin
      unique case (b_step_ff)
         2'd0:    b_pat_cur = b_pat_ff;
         2'd1:    b_pat_cur = PAT_END1;
         default: b_pat_cur = PAT_END0;
      endcase
   end

   // five newest samples along the filter direction
   always_comb begin
      win[0] = taps_ff[0];
      for (int j = 1; j < TAPS; j++) begin
         win[j] = b_vert_ff ? line_rd_ff[b_lane_ff - LANE_W'(j)] : taps_ff[j];
      end
   end

   // ---------------------------------------------------------------- tap register
   always_comb begin
      c_valid_in = c_valid_ff;
      if (c_free) begin
         c_valid_in = b_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (b_emit) begin
         for (int k = 0; k < TAPS; k++) begin
            c_tap_ff[k] <= win[tap_src(b_pat_cur, TAP_IDX_W'(k))];
         end
         c_last_ff <= b_lastsub;
         c_eof_ff  <= b_flush_ff && (b_step_ff == 2'd2) && b_eof_ff;
      end
   end

   // ---------------------------------------------------------------- mac
   always_comb begin
      acc = ACC_W'(ROUND_ADD);
      for (int k = 0; k < TAPS; k++) begin
         acc = acc + ACC_W'(c_tap_ff[k]) * ACC_W'(WEIGHTS[k]);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (o_free) begin
         rsp_valid_in = c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_valid_ff && o_free) begin
         rsp_data_ff <= acc[ROUND_BITS +: SAMPLE_W];
         rsp_last_ff <= c_last_ff;
         rsp_eof_ff  <= c_eof_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.filtered     = rsp_data_ff;
   assign rsp_chan.last_of_run  = rsp_last_ff;
   assign rsp_chan.end_of_frame = rsp_eof_ff;

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_W'(RST_SIZE);
         height_ff    <= SIZE_W'(RST_SIZE);
         vert_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         b_valid_ff   <= 1'b0;
         b_step_ff    <= 2'd0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         vert_ff      <= vert_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         b_valid_ff   <= b_valid_in;
         b_step_ff    <= b_step_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer payload, qualified by b_valid_ff
   always_ff @(posedge clock) begin
      b_vert_ff  <= b_vert_in;
      b_flush_ff <= b_flush_in;
      b_pat_ff   <= b_pat_in;
      b_eof_ff   <= b_eof_in;
      b_lane_ff  <= b_lane_in;
   end

`ifndef SYNTHESIS
   // position never leaves the clamped frame
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= wlast) && (row_ff <= hlast))
      else $error("raster position outside frame");

   // only a flushing word walks past its first result
   a_step_flush: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && (b_step_ff != 2'd0)) |-> b_flush_ff)
      else $error("sequencer stepped on a non-flushing word");

   // frame end only on the last result of its word
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_eof_ff) |-> rsp_last_ff)
      else $error("end_of_frame without last_of_run");

   // no word enters while a flush still has results to hand out
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_flush_ff && (b_step_ff != 2'd2)) |-> !req_acc)
      else $error("word accepted during flush");
`endif

endmodule

`default_nettype wire

// ===== dv/five_tap_mirrored_blur_test.sv =====
// self-checking testbench of the five-tap mirrored blur: directed table, random frames, extremes
`default_nettype none

module five_tap_mirrored_blur_test;

   import ftmb_pkg::*;

   // line length the block is built with, mirrored by the local line copy
   localparam int LINE_LEN      = 4096;
   localparam int LINE_ROWS     = 4;
   // sequencer, tap and mac registers plus a three-word flush, with margin
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT     = 15_000_000;
   localparam int RANDOM_WORDS  = 170;
   localparam int OPENING_ROWS  = 25;
   localparam int MAX_WAIT      = 11;

   localparam int unsigned TAP_WEIGHT [TAPS] = '{13, 64, 102, 64, 13};
   localparam int unsigned HALF_LSB         = 128;

   // csr index past the three registers, the block must ignore it
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum logic {
      STEP_SAMPLE,
      STEP_WRITE
   } step_kind_type;

   typedef enum logic [1:0] {
      TEX_NOISE,
      TEX_EXTREME,
      TEX_FLAT
   } texture_type;

   typedef struct packed {
      sample_type filtered;
      logic       last_of_run;
      logic       end_of_frame;
   } blur_word_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [SIZE_W-1:0]      data;
      sample_type             sample;
      logic                   pinned;
      sample_type             pinned_value;
   } plan_row_type;

   // opening table: a flat field gives itself back, so those rows carry the value
   localparam plan_row_type OPENING [OPENING_ROWS] = '{
      // reset sizes, first two words of a row give nothing
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
      // width below the floor, used as eight, restarts the frame
      '{STEP_WRITE,  REG_WIDTH,  13'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
      // unknown index mid-row, the row must carry on
      '{STEP_WRITE,  REG_UNUSED, 13'h1FFF, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
      // end of row, flushes three
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b1, 16'hFFFF},
      // second row, alternating extremes through the mirrored edges
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'hFFFF, 1'b0, 16'h0000},
      // height above the ceiling, used as the max, restarts again
      '{STEP_WRITE,  REG_HEIGHT, 13'h1FFF, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'h0000, 1'b0, 16'h0000},
      '{STEP_SAMPLE, REG_WIDTH,  13'h0000, 16'h0000, 1'b1, 16'h0000}
   };

   logic clock = 1'b0;
   logic reset;

   ftmb_req_if req_chan ();
   ftmb_rsp_if rsp_chan ();
   ftmb_csr_if csr_chan ();

   five_tap_mirrored_blur #(
      .MAX_WIDTH (LINE_LEN)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // local copy of the block state
   sample_type        line_copy [LINE_ROWS*LINE_LEN];
   sample_type        recent [4];
   int unsigned       col_pos;
   int unsigned       row_pos;
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   logic              mode_reg;

   // smoothed words still owed by the block, oldest first
   blur_word_type smoothed_due [$];

   int unsigned failures;
   bit          send_rush;
   bit          take_rush;

   function automatic int unsigned clamped(input logic [SIZE_W-1:0] v, input int unsigned top);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > top) return top;
      return v;
   endfunction

   // edge reflection, the low edge sample not repeated, the high edge sample repeated
   function automatic int unsigned reflect(input int idx, input int span);
      if (idx < 0) return -idx;
      if (idx >= span) return 2 * span - 1 - idx;
      return idx;
   endfunction

   function automatic sample_type row_tap(input int unsigned c, input int unsigned m,
                                          input sample_type cur);
      int unsigned back;
      if (m >= c) return cur;
      back = c - 1 - m;
      if (back > 3) back = 3;
      return recent[back];
   endfunction

   function automatic sample_type column_tap(input int unsigned r, input int unsigned c,
                                             input int unsigned m, input sample_type cur);
      if (m >= r) return cur;
      return line_copy[(m % LINE_ROWS) * LINE_LEN + c];
   endfunction

   // per-item stall length, with stretches of back-to-back words
   function automatic int unsigned draw_wait(inout bit rush);
      if ($urandom_range(0, 39) == 0) rush = !rush;
      return rush ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic sample_type fresh_sample(input texture_type tex, input sample_type base);
      case (tex)
         TEX_NOISE:   return sample_type'($urandom);
         TEX_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
         default:     return base ^ sample_type'($urandom_range(0, 255));
      endcase
   endfunction

   // blur one accepted sample: queue the words it releases, then store it
   task automatic smooth_and_store(input sample_type cur, input logic pinned,
                                   input sample_type pinned_value);
      int unsigned   w, h, c, r, span, along, lo, hi, p, m, acc;
      int            k;
      blur_word_type res;
      w = clamped(width_reg, LINE_LEN);
      h = clamped(height_reg, MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      span  = mode_reg ? h : w;
      along = mode_reg ? r : c;
      // lags two behind, the last of the run flushes the tail
      if (along >= 2) begin
         lo = along - 2;
         hi = (along == span - 1) ? span - 1 : lo;
         for (p = lo; p <= hi; p++) begin
            acc = 0;
            for (k = 0; k < TAPS; k++) begin
               m = reflect(int'(p) + k - TAPS / 2, span);
               acc += TAP_WEIGHT[k] * (mode_reg ? column_tap(r, c, m, cur) : row_tap(c, m, cur));
            end
            res.filtered     = pinned ? pinned_value : sample_type'((acc + HALF_LSB) >> ROUND_BITS);
            res.last_of_run  = (p == hi);
            res.end_of_frame = mode_reg ? (p == h - 1 && c == w - 1) : (r == h - 1 && p == w - 1);
            smoothed_due.push_back(res);
         end
      end
      line_copy[(r % LINE_ROWS) * LINE_LEN + c] = cur;
      recent[3] = recent[2];
      recent[2] = recent[1];
      recent[1] = recent[0];
      recent[0] = cur;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   // offer one word at a falling edge, hold it until taken; returns at a falling edge
   task automatic feed_sample(input sample_type value, input logic pinned,
                              input sample_type pinned_value);
      int unsigned gap;
      gap = draw_wait(send_rush);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  = 1'b1;
      req_chan.sample = value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      smooth_and_store(value, pinned, pinned_value);
      @(negedge clock);
   endtask

   // register write, only once the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      req_chan.valid = 1'b0;
      while (smoothed_due.size() != 0) @(negedge clock);
      // words that release nothing may still be in the pipe
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_chan.index = idx;
      csr_chan.data  = value;
      csr_chan.valid = 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         REG_WIDTH:  width_reg  = value;
         REG_HEIGHT: height_reg = value;
         REG_MODE:   mode_reg   = value[0];
         default:    ;
      endcase
      // any known register restarts the frame, stored samples stay
      if (idx != REG_UNUSED) begin
         col_pos = 0;
         row_pos = 0;
      end
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // one setting, then a stream with a possible ignored write somewhere inside
   task automatic run_phase(input logic [SIZE_W-1:0] w_set, input logic [SIZE_W-1:0] h_set,
                            input logic vert, input int unsigned words);
      int unsigned       i, spare_at;
      logic [SIZE_W-1:0] junk;
      texture_type       tex;
      sample_type        base;
      junk = SIZE_W'($urandom);
      write_reg(REG_WIDTH, w_set);
      write_reg(REG_HEIGHT, h_set);
      write_reg(REG_MODE, {junk[SIZE_W-1:1], vert});
      spare_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, words - 1) : words;
      tex  = texture_type'($urandom_range(0, 2));
      base = sample_type'($urandom);
      for (i = 0; i < words; i++) begin
         if (i == spare_at) begin
            junk = SIZE_W'($urandom);
            write_reg(REG_UNUSED, junk);
         end
         feed_sample(fresh_sample(tex, base), 1'b0, '0);
      end
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   // result side: random stalls, every word checked against the oldest owed one
   initial begin : take_words
      int unsigned   gap;
      blur_word_type want;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = draw_wait(take_rush);
         if (gap != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (smoothed_due.size() == 0) begin
            $display("%0t: word expected none actual filtered=%0h last=%0b eof=%0b", $time,
                     rsp_chan.filtered, rsp_chan.last_of_run, rsp_chan.end_of_frame);
            failures++;
         end else begin
            want = smoothed_due.pop_front();
            check_field("filtered", want.filtered, rsp_chan.filtered);
            check_field("last_of_run", want.last_of_run, rsp_chan.last_of_run);
            check_field("end_of_frame", want.end_of_frame, rsp_chan.end_of_frame);
         end
         @(negedge clock);
      end
   end

   // main sequence: reset, opening table, random frames, size extremes
   initial begin : drive_words
      int unsigned       i, w, h, words, random_words;
      logic [SIZE_W-1:0] w_set, h_set;
      logic              vert;
      failures   = 0;
      send_rush  = 1'b0;
      take_rush  = 1'b0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = SIZE_W'(RST_SIZE);
      height_reg = SIZE_W'(RST_SIZE);
      mode_reg   = 1'b0;
      recent     = '{default: '0};
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      csr_chan.valid  = 1'b0;
      csr_chan.index  = '0;
      csr_chan.data   = '0;
      reset = 1'b1;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < OPENING_ROWS; i++) begin
         if (OPENING[i].kind == STEP_WRITE) begin
            write_reg(OPENING[i].idx, OPENING[i].data);
         end else begin
            feed_sample(OPENING[i].sample, OPENING[i].pinned, OPENING[i].pinned_value);
         end
      end

      // small frames, either direction, now and then a size under the floor
      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         vert  = 1'($urandom_range(0, 1));
         w_set = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom_range(0, 7)) :
                                               SIZE_W'($urandom_range(8, 14));
         h_set = ($urandom_range(0, 7) == 0) ? SIZE_W'($urandom_range(0, 7)) :
                                               SIZE_W'($urandom_range(8, 11));
         w = clamped(w_set, LINE_LEN);
         h = clamped(h_set, MAX_HEIGHT);
         // whole frames or rows plus a ragged tail, the next write cuts it short
         if (vert) words = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
         else words = w * $urandom_range(2, 6) + $urandom_range(0, w - 1);
         run_phase(w_set, h_set, vert, words);
         random_words += words;
      end

      // both sizes at zero, column mode across a frame wrap
      run_phase('0, '0, 1'b1, 2 * MIN_SIZE * MIN_SIZE + 5);
      // width above the ceiling, used as the max, opening stretch of a long row
      run_phase('1, SIZE_W'(MAX_HEIGHT), 1'b0, 40);
      // exact max width with the height clamp
      run_phase(SIZE_W'(LINE_LEN), '1, 1'b0, 40);

      req_chan.valid = 1'b0;
      while (smoothed_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("five_tap_mirrored_blur_test: PASS");
      end else begin
         $display("five_tap_mirrored_blur_test: FAIL");
      end
      $finish;
   end

   // watchdog for a hung handshake
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("five_tap_mirrored_blur_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ftmb_pkg.sv
rtl/ftmb_intf.sv
rtl/five_tap_mirrored_blur.sv
dv/five_tap_mirrored_blur_test.sv
